// ===== rtl/pblep_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pblep_pkg
// shared types and register indexes of the polyblep residual block
// ----------------------------------------------------------------------------
package pblep_pkg;

  // configuration register indexes
  localparam logic CFG_WAVEFORM  = 1'b0;
  localparam logic CFG_PHASE_INC = 1'b1;

  // how the residual of one request is shaped
  typedef struct packed {
    logic active;    // a discontinuity lies next to the previous sample
    logic low_side;  // use the t <= 0 branch of the residual
    logic invert;    // mid-cycle square step, opposite sign
  } pblep_flags_t;

endpackage

// ===== rtl/pblep_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pblep_div
// bit-serial restoring divider, one quotient bit per cycle, saturating at 1.0
// ----------------------------------------------------------------------------
module pblep_div #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 24,
  parameter int FRAC  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] mag,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [FRAC:0]    quot_sat
);

  localparam int SH_W  = NUM_W + FRAC;
  localparam int CNT_W = $clog2(SH_W + 1);
  localparam int Q_W   = FRAC + 1;
  localparam logic [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC;

  logic [SH_W-1:0]  num_sr;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [Q_W-1:0]   quot;
  logic             ovf;
  logic [CNT_W-1:0] cnt;
  logic             busy;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_next;
  logic             sat;

  // remainder stays below the divisor, so one trial subtract per bit
  assign trial    = {rem, num_sr[SH_W-1]};
  assign diff     = trial - {1'b0, den_q};
  assign ge       = (trial >= {1'b0, den_q});
  assign rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SH_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sr <= {mag, {FRAC{1'b0}}};
      rem    <= '0;
      quot   <= '0;
      ovf    <= 1'b0;
      den_q  <= den;
    end else if (busy) begin
      num_sr <= num_sr << 1;
      rem    <= rem_next;
      quot   <= {quot[Q_W-2:0], ge};
      ovf    <= ovf | quot[Q_W-1];
    end
  end

  // anything above 1.0 clamps to 1.0
  assign sat      = ovf | (quot[Q_W-1] & (|quot[Q_W-2:0]));
  assign quot_sat = sat ? Q_ONE : quot;

endmodule

// ===== rtl/pblep_shape.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pblep_shape
// squares t and applies the two-sided quadratic residual, doubled
// ----------------------------------------------------------------------------
module pblep_shape #(
  parameter int FRAC = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [FRAC:0]          t,
  input  pblep_pkg::pblep_flags_t flags,
  output logic                   done,
  output logic [FRAC+1:0]        result
);

  localparam int SQ_W = 2 * FRAC + 2;
  localparam int R_W  = FRAC + 3;
  localparam logic [SQ_W:0] RND = (SQ_W + 1)'(1) << (FRAC - 1);
  localparam logic [R_W-1:0] R_ONE = R_W'(1) << FRAC;

  logic [SQ_W-1:0]         sq;
  logic [FRAC:0]           t_q;
  pblep_pkg::pblep_flags_t fl_q;
  logic                    sq_vld;

  logic [SQ_W:0]  sq_rnd;
  logic [R_W-1:0] tt;
  logic [R_W-1:0] pos;
  logic [R_W-1:0] res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      sq_vld <= start;
      done   <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sq   <= t * t;
      t_q  <= t;
      fl_q <= flags;
    end
    if (sq_vld) begin
      result <= res_full[FRAC+1:0];
    end
  end

  // t^2 rounded half up back to the output scale
  assign sq_rnd = {1'b0, sq} + RND;
  assign tt     = sq_rnd[SQ_W:FRAC];
  // 2t - t^2 - 1; negated on the low branch or for an inverted step, not both
  assign pos    = (R_W'(t_q) << 1) - tt - R_ONE;

  always_comb begin
    if (!fl_q.active) begin
      res_full = '0;
    end else if (fl_q.low_side ^ fl_q.invert) begin
      res_full = R_W'(0) - pos;
    end else begin
      res_full = pos;
    end
  end

endmodule

// ===== rtl/polyblep_residual_saw_square_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyblep_residual_saw_square_top
// polyblep anti-aliasing correction for sawtooth and square oscillators
// ----------------------------------------------------------------------------
// Each request carries one oscillator phase (unsigned fraction of a cycle,
// PHASE_BITS wide) and yields exactly one correction (signed, OUT_FRAC_BITS
// fraction bits, range -1..+1) for the previous sample. A phase wrap, and in
// square mode a crossing of one half, marks a discontinuity; its distance
// from the previous sample is divided by the phase increment with a
// bit-serial divider that retires one quotient bit per cycle. The block
// works on one request at a time: the next request is accepted only
// after the current one has passed the capture stage, the
// PHASE_BITS + 1 + OUT_FRAC_BITS steps of the divider and the square
// and output stages and the result sits in the output register. A finished
// correction waits in an output register, so a stalled output side does
// not hold off the next phase until a second result is ready. Configuration
// writes take effect at once and are expected only while the block is idle;
// a phase increment of zero is taken as one.
// ----------------------------------------------------------------------------
module polyblep_residual_saw_square_top #(
  parameter int PHASE_BITS    = 24,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // phase input stream
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((PHASE_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // [PHASE_BITS-1:0] phase
  // correction output stream
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [((OUT_FRAC_BITS + 9) / 8) * 8 - 1:0] m_tdata, // [OUT_FRAC_BITS+1:0] correction
  // configuration write port
  input  logic                                   cfg_we,
  input  logic                                   cfg_addr,
  input  logic [PHASE_BITS-1:0]                  cfg_data
);

  localparam int PB    = PHASE_BITS;
  localparam int FRAC  = OUT_FRAC_BITS;
  localparam int OUT_W = FRAC + 2;
  localparam int MAG_W = PB + 1;
  localparam int M_TDATA_W = ((OUT_FRAC_BITS + 9) / 8) * 8;

  // phase 1.0 and 0.5 one bit wider than the phase
  localparam logic [MAG_W-1:0] PH_ONE  = MAG_W'(1) << PB;
  localparam logic [MAG_W-1:0] PH_HALF = MAG_W'(1) << (PB - 1);
  localparam logic [PB-1:0]    INC_RESET = PB'(65536);
  localparam logic [OUT_W-1:0] OUT_ONE   = OUT_W'(1) << FRAC;

  // control sequence of one request
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,  // ready for a phase
    ST_DIV   = 4'b0010,  // serial divide running
    ST_SHAPE = 4'b0100,  // square and residual
    ST_WAIT  = 4'b1000   // result held, output register still full
  } state_t;

  state_t                  state;
  state_t                  state_next;

  // configuration
  logic                    waveform;
  logic [PB-1:0]           phase_inc;

  // phase history
  logic [PB-1:0]           prev_phase;
  logic [PB-1:0]           prev2_phase;

  // captured request
  logic [MAG_W-1:0]        mag;
  pblep_pkg::pblep_flags_t flags;
  logic                    div_start;

  logic [PB-1:0]           ph;
  logic                    accept;
  logic                    wrap_now;
  logic                    wrap_prev;
  logic                    half_step;
  logic [MAG_W-1:0]        mag_next;
  pblep_pkg::pblep_flags_t flags_next;
  logic [PB-1:0]           den;

  logic                    div_done;
  logic [FRAC:0]           t_sat;
  logic                    shp_done;
  logic [OUT_W-1:0]        shp_result;

  logic                    out_free;
  logic                    out_load;
  logic [OUT_W-1:0]        out_reg;
  logic                    out_vld;

  assign ph       = s_tdata[PB-1:0];
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid & s_tready;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      waveform  <= 1'b0;
      phase_inc <= INC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pblep_pkg::CFG_WAVEFORM:  waveform  <= cfg_data[0];
        pblep_pkg::CFG_PHASE_INC: phase_inc <= cfg_data;
        default: ;
      endcase
    end
  end

  // discontinuity detect against the two previous phases
  assign wrap_now  = (prev_phase > ph);
  assign wrap_prev = (prev2_phase > prev_phase);
  assign half_step = waveform &
                     ((~prev_phase[PB-1] & ph[PB-1]) |
                      (~prev2_phase[PB-1] & prev_phase[PB-1]));

  always_comb begin
    mag_next   = '0;
    flags_next = '0;
    if (wrap_now) begin
      // wrap right after the previous sample: offset is prev - 1.0
      mag_next            = PH_ONE - {1'b0, prev_phase};
      flags_next.active   = 1'b1;
      flags_next.low_side = 1'b1;
    end else if (wrap_prev) begin
      // wrap right before the previous sample
      mag_next            = {1'b0, prev_phase};
      flags_next.active   = 1'b1;
      flags_next.low_side = (prev_phase == '0);
    end else if (half_step) begin
      flags_next.active = 1'b1;
      flags_next.invert = 1'b1;
      if (prev_phase[PB-1]) begin
        mag_next            = {2'b00, prev_phase[PB-2:0]};
        flags_next.low_side = (prev_phase[PB-2:0] == '0);
      end else begin
        mag_next            = PH_HALF - {1'b0, prev_phase};
        flags_next.low_side = 1'b1;
      end
    end
  end

  // zero increment divides as one
  assign den = (phase_inc == '0) ? PB'(1) : phase_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_phase  <= '0;
      prev2_phase <= '0;
      div_start   <= 1'b0;
    end else begin
      div_start <= accept;
      if (accept) begin
        prev2_phase <= prev_phase;
        prev_phase  <= ph;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag   <= mag_next;
      flags <= flags_next;
    end
  end

  pblep_div #(
    .NUM_W (MAG_W),
    .DEN_W (PB),
    .FRAC  (FRAC)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .mag      (mag),
    .den      (den),
    .done     (div_done),
    .quot_sat (t_sat)
  );

  pblep_shape #(
    .FRAC (FRAC)
  ) u_shape (
    .clk    (clk),
    .rst    (rst),
    .start  (div_done),
    .t      (t_sat),
    .flags  (flags),
    .done   (shp_done),
    .result (shp_result)
  );

  // output register takes a result when empty or being emptied
  assign out_free = ~out_vld | m_tready;
  assign out_load = ((state == ST_SHAPE) & shp_done & out_free) |
                    ((state == ST_WAIT) & out_free);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_SHAPE;
      ST_SHAPE: if (shp_done) state_next = out_free ? ST_IDLE : ST_WAIT;
      ST_WAIT:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      out_vld <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_reg <= shp_result;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = M_TDATA_W'(out_reg);

  // divider finishes only while the sequence waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside divide phase");

  // residual finishes only while the sequence waits for it
  a_shp_done_in_shape: assert property (@(posedge clk) disable iff (rst)
    shp_done |-> state == ST_SHAPE)
    else $error("residual finished outside shape phase");

  // an accepted phase launches the divider on the next cycle
  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    accept |=> (div_start && state == ST_DIV))
    else $error("accepted phase did not start the divider");

  // a delivered correction stays within -1..+1
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(out_reg) <= $signed(OUT_ONE) &&
                  $signed(out_reg) >= -$signed(OUT_ONE)))
    else $error("correction out of range");

endmodule
